// ----- src/bbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int CNT_W       = COL_W + 1;
   localparam int ROW_W       = 13;
   localparam int WIDTH_W     = 11;
   localparam int CHAN_W      = 8;
   localparam int NCHAN       = 4;
   localparam int COL_SUM_W   = 10;
   localparam int WIN_SUM_W   = 12;
   localparam int DIV9_MUL    = 3641;
   localparam int DIV9_SHIFT  = 15;
   localparam int PROD_W      = WIN_SUM_W + 12;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [WIDTH_W-1:0]     width_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [ROW_W:0]         row_ext_type;
   typedef logic [COL_W-1:0]       col_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [CHAN_W-1:0]      chan_type;
   typedef logic [COL_SUM_W-1:0]   col_acc_type;
   typedef logic [WIN_SUM_W-1:0]   win_acc_type;
   typedef logic [PROD_W-1:0]      prod_type;

   localparam csr_index_type CSR_IMAGE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = csr_index_type'(1);
   localparam width_type     RESET_WIDTH      = width_type'(640);
   localparam row_type       RESET_HEIGHT     = row_type'(480);

   // channel 0 is red, 3 is alpha
   typedef logic [NCHAN-1:0][CHAN_W-1:0]    pixel_type;
   // entry 0 is the upper row, 2 the newest row
   typedef pixel_type [2:0]                 column_type;
   typedef logic [NCHAN-1:0][COL_SUM_W-1:0] col_sum_type;
   typedef logic [NCHAN-1:0][WIN_SUM_W-1:0] win_sum_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0] row_ok;
      logic [2:0] col_ok;
      logic       last;
   } ctl_type;

endpackage

`default_nettype wire

// ----- src/box_blur_3x3_rgba.sv -----
// a result leaves rsp once the beat that completes its window has passed the pipeline below;
// in stream terms a result lags its pixel by image_width+1 beats that are not dropped.
// throughput: one beat per clock unless rsp stalls; set by the line store read port and the cell row shift.
// pipeline: line store read, window cells, column/window sum, multiply by 1/9, output register.
// reset (synchronous) clears counters, drain flag and valids and loads the config registers
// with 640 by 480; line stores and window cells are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgba (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire bbr_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output bbr_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bbr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bbr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   bbr_pkg::width_type csr_width_ff;
   bbr_pkg::row_type   csr_height_ff;
   bbr_pkg::cnt_type   eff_w;
   bbr_pkg::row_type   eff_h;

   // position counters
   bbr_pkg::col_type   in_col_ff, in_col_in;
   bbr_pkg::row_type   in_row_ff, in_row_in;
   bbr_pkg::col_type   out_col_ff, out_col_in;
   bbr_pkg::row_type   out_row_ff, out_row_in;
   logic               draining_ff, draining_in;

   logic               accept, proc, primed;
   bbr_pkg::cnt_type   in_col_nx, out_col_nx;
   bbr_pkg::row_ext_type in_row_nx, out_row_nx;
   logic               in_eol, in_lastrow, out_eol, out_lastrow;
   bbr_pkg::ctl_type   ctl;
   bbr_pkg::pixel_type pix;
   bbr_pkg::pixel_type bank0_rd, bank1_rd;

   // pipeline
   logic               s1_v_ff, s1_v_in, s1_emit_ff, s1_par_ff;
   bbr_pkg::pixel_type s1_pix_ff;
   bbr_pkg::ctl_type   s1_ctl_ff;
   logic               s2_v_ff, s2_v_in;
   bbr_pkg::ctl_type   s2_ctl_ff;
   logic               s3_v_ff, s3_v_in, s3_last_ff;
   bbr_pkg::win_sum_type s3_sum_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   bbr_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               out_ready, s3_ready, s2_ready, s1_go;

   bbr_pkg::column_type  chain [4];
   bbr_pkg::col_sum_type col_sums [3];
   bbr_pkg::win_sum_type win_sum;

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= bbr_pkg::RESET_WIDTH;
         csr_height_ff <= bbr_pkg::RESET_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bbr_pkg::CSR_IMAGE_WIDTH: begin
               csr_width_ff <= csr_wdata[bbr_pkg::WIDTH_W-1:0];
            end
            bbr_pkg::CSR_IMAGE_HEIGHT: begin
               csr_height_ff <= csr_wdata[bbr_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (csr_width_ff == '0) begin
         eff_w = bbr_pkg::cnt_type'(1);
      end else if (32'(csr_width_ff) > 32'(bbr_pkg::MAX_WIDTH)) begin
         eff_w = bbr_pkg::cnt_type'(bbr_pkg::MAX_WIDTH);
      end else begin
         eff_w = bbr_pkg::cnt_type'(csr_width_ff);
      end
      eff_h = (csr_height_ff == '0) ? bbr_pkg::row_type'(1) : csr_height_ff;
   end

   // ---------------- input side ----------------
   assign accept = req_valid && !req_stall;
   // a flush outside a drain or a pixel inside one is dropped
   assign proc   = accept && (req_data.flush == draining_ff);

   assign in_col_nx   = bbr_pkg::cnt_type'(in_col_ff) + bbr_pkg::cnt_type'(1);
   assign in_eol      = in_col_nx >= eff_w;
   assign in_row_nx   = bbr_pkg::row_ext_type'(in_row_ff) + bbr_pkg::row_ext_type'(1);
   assign in_lastrow  = in_row_nx >= bbr_pkg::row_ext_type'(eff_h);
   assign out_col_nx  = bbr_pkg::cnt_type'(out_col_ff) + bbr_pkg::cnt_type'(1);
   assign out_eol     = out_col_nx >= eff_w;
   assign out_row_nx  = bbr_pkg::row_ext_type'(out_row_ff) + bbr_pkg::row_ext_type'(1);
   assign out_lastrow = out_row_nx >= bbr_pkg::row_ext_type'(eff_h);

   assign primed = (in_row_ff > bbr_pkg::row_type'(1))
                || (in_row_ff == bbr_pkg::row_type'(1) && in_col_ff != '0);

   always_comb begin
      ctl.row_ok = {!out_lastrow, 1'b1, out_row_ff != '0};
      ctl.col_ok = {!out_eol, 1'b1, out_col_ff != '0};
      ctl.last   = out_lastrow && out_eol;
   end

   always_comb begin
      if (req_data.flush) begin
         pix = '0;
      end else begin
         pix[0] = req_data.in_red;
         pix[1] = req_data.in_green;
         pix[2] = req_data.in_blue;
         pix[3] = req_data.in_alpha;
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      draining_in = draining_ff;
      if (proc) begin
         if (in_eol) begin
            in_col_in = '0;
            in_row_in = in_row_nx[bbr_pkg::ROW_W-1:0];
         end else begin
            in_col_in = in_col_nx[bbr_pkg::COL_W-1:0];
         end
         if (!req_data.flush && in_lastrow && in_eol) begin
            draining_in = 1'b1;
         end
         if (primed) begin
            if (ctl.last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               draining_in = 1'b0;
            end else if (out_eol) begin
               out_col_in = '0;
               out_row_in = out_row_nx[bbr_pkg::ROW_W-1:0];
            end else begin
               out_col_in = out_col_nx[bbr_pkg::COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         draining_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         draining_ff <= draining_in;
      end
   end

   // line stores by row parity: the bank of the current parity holds the row
   // two above, the other bank the row just above
   bbr_ram #(
      .WIDTH ($bits(bbr_pkg::pixel_type)),
      .DEPTH (bbr_pkg::MAX_WIDTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (proc && !in_row_ff[0]),
      .wr_addr (in_col_ff),
      .wr_data (pix),
      .rd_en   (proc),
      .rd_addr (in_col_ff),
      .rd_data (bank0_rd)
   );

   bbr_ram #(
      .WIDTH ($bits(bbr_pkg::pixel_type)),
      .DEPTH (bbr_pkg::MAX_WIDTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (proc && in_row_ff[0]),
      .wr_addr (in_col_ff),
      .wr_data (pix),
      .rd_en   (proc),
      .rd_addr (in_col_ff),
      .rd_data (bank1_rd)
   );

   // ---------------- handshake chain ----------------
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   // the window may only shift once the item summing it has moved on
   assign s1_go     = s1_v_ff && s2_ready;
   assign req_stall = s1_v_ff && !s1_go;

   assign s1_v_in      = proc || (s1_v_ff && !s1_go);
   assign s2_v_in      = (s1_go && s1_emit_ff) || (s2_v_ff && !s3_ready);
   assign s3_v_in      = (s2_v_ff && s3_ready) || (s3_v_ff && !out_ready);
   assign rsp_valid_in = (s3_v_ff && out_ready) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         s1_pix_ff  <= pix;
         s1_par_ff  <= in_row_ff[0];
         s1_emit_ff <= primed;
         s1_ctl_ff  <= ctl;
      end
      if (s1_go) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
      if (s2_v_ff && s3_ready) begin
         s3_sum_ff  <= win_sum;
         s3_last_ff <= s2_ctl_ff.last;
      end
      if (s3_v_ff && out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- window: row of column cells ----------------
   always_comb begin
      chain[3][0] = s1_par_ff ? bank1_rd : bank0_rd;
      chain[3][1] = s1_par_ff ? bank0_rd : bank1_rd;
      chain[3][2] = s1_pix_ff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_cell
      bbr_cell u_cell (
         .clock    (clock),
         .shift_en (s1_go),
         .col_in   (chain[i+1]),
         .row_ok   (s2_ctl_ff.row_ok),
         .col_out  (chain[i]),
         .col_sum  (col_sums[i])
      );
   end

   always_comb begin
      for (int ch = 0; ch < bbr_pkg::NCHAN; ch++) begin
         win_sum[ch] = bbr_pkg::win_acc_type'(col_sums[1][ch]);
         if (s2_ctl_ff.col_ok[0]) begin
            win_sum[ch] = win_sum[ch] + bbr_pkg::win_acc_type'(col_sums[0][ch]);
         end
         if (s2_ctl_ff.col_ok[2]) begin
            win_sum[ch] = win_sum[ch] + bbr_pkg::win_acc_type'(col_sums[2][ch]);
         end
      end
   end

   // ---------------- divide by 9 and output beat ----------------
   // sum * 3641 >> 15 is exact floor(sum / 9) for sums up to 9 * 255
   always_comb begin
      bbr_pkg::prod_type prod [bbr_pkg::NCHAN];
      for (int ch = 0; ch < bbr_pkg::NCHAN; ch++) begin
         prod[ch] = bbr_pkg::prod_type'(s3_sum_ff[ch])
                  * bbr_pkg::prod_type'(bbr_pkg::DIV9_MUL);
      end
      rsp_data_in.out_red    = bbr_pkg::chan_type'(prod[0] >> bbr_pkg::DIV9_SHIFT);
      rsp_data_in.out_green  = bbr_pkg::chan_type'(prod[1] >> bbr_pkg::DIV9_SHIFT);
      rsp_data_in.out_blue   = bbr_pkg::chan_type'(prod[2] >> bbr_pkg::DIV9_SHIFT);
      rsp_data_in.out_alpha  = bbr_pkg::chan_type'(prod[3] >> bbr_pkg::DIV9_SHIFT);
      rsp_data_in.frame_last = s3_last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_stall_means_busy : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_v_ff)
      else $error("input stalled with an empty first stage");

   a_s2_holds : assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !s3_ready |=> s2_v_ff)
      else $error("window stage item lost while blocked");

   a_s3_holds : assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !out_ready |=> s3_v_ff && $stable(s3_sum_ff))
      else $error("sum stage changed while blocked");

   a_frame_end_clears : assert property (@(posedge clock) disable iff (reset)
      proc && primed && ctl.last |=>
         out_col_ff == '0 && out_row_ff == '0 && in_col_ff == '0 && !draining_ff)
      else $error("counters not cleared after last pixel of frame");

endmodule

`default_nettype wire

// ----- src/bbr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/bbr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bbr_cell (
   input  wire logic                clock,
   input  wire logic                shift_en,
   input  wire bbr_pkg::column_type col_in,
   input  wire logic [2:0]          row_ok,
   output bbr_pkg::column_type      col_out,
   output bbr_pkg::col_sum_type     col_sum
);

   bbr_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // per channel column sum, rows outside the image count as zero
   always_comb begin
      for (int ch = 0; ch < bbr_pkg::NCHAN; ch++) begin
         col_sum[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            if (row_ok[r]) begin
               col_sum[ch] = col_sum[ch] + bbr_pkg::col_acc_type'(col_ff[r][ch]);
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- sim/tb_box_blur_3x3_rgba.sv -----
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgba;

   localparam int BOX_TAPS = 9;
   localparam bbr_pkg::csr_index_type CSR_SPARE = bbr_pkg::csr_index_type'(15);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bbr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bbr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bbr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bbr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   box_blur_3x3_rgba DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // blur predictor state
   bbr_pkg::width_type cfg_width;
   bbr_pkg::row_type cfg_height;
   bbr_pkg::pixel_type line_upper [bbr_pkg::MAX_WIDTH];
   bbr_pkg::pixel_type line_middle [bbr_pkg::MAX_WIDTH];
   bbr_pkg::pixel_type win_px [3][3];
   int px_col, px_row, res_col, res_row;
   bit drain_on;

   bbr_pkg::req_type pixel_feed [$];
   bbr_pkg::rsp_type blurred_px [$];
   int items_pushed = 0;
   int items_taken = 0;
   int rsp_beats = 0;
   int hold_left = 0;
   int errors = 0;
   int feed_gap_pct = 0;
   int sink_stall_pct = 0;

   function automatic int eff_w();
      if (cfg_width == 0) return 1;
      if (cfg_width > bbr_pkg::MAX_WIDTH) return bbr_pkg::MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int eff_h();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
   endfunction

   function automatic void clear_frame();
      win_px = '{default: '0};
      px_col = 0;
      px_row = 0;
      res_col = 0;
      res_row = 0;
      drain_on = 1'b0;
   endfunction

   task automatic blur_step(input bbr_pkg::req_type item);
      bbr_pkg::pixel_type px, top, mid;
      int w, h, idx, r, c, ch, sum;
      bit primed, last;
      bit row_ok [3];
      bit col_ok [3];
      logic [7:0] avg [bbr_pkg::NCHAN];
      bbr_pkg::rsp_type res;
      w = eff_w();
      h = eff_h();
      if (item.flush != drain_on) return;
      px = item.flush ? bbr_pkg::pixel_type'(0)
                      : {item.in_alpha, item.in_blue, item.in_green, item.in_red};
      idx = (px_col < bbr_pkg::MAX_WIDTH) ? px_col : 0;
      top = line_upper[idx];
      mid = line_middle[idx];
      line_upper[idx] = mid;
      line_middle[idx] = px;
      for (r = 0; r < 3; r++) begin
         win_px[r][0] = win_px[r][1];
         win_px[r][1] = win_px[r][2];
      end
      win_px[0][2] = top;
      win_px[1][2] = mid;
      win_px[2][2] = px;
      primed = px_row >= 2 || (px_row == 1 && px_col >= 1);
      if (!item.flush && px_row + 1 >= h && px_col + 1 >= w) drain_on = 1'b1;
      if (px_col + 1 >= w) begin
         px_col = 0;
         px_row = (px_row + 1) % (1 << bbr_pkg::ROW_W);
      end else begin
         px_col++;
      end
      if (!primed) return;
      // neighbors outside the image are masked, divisor stays fixed
      row_ok[0] = res_row > 0;
      row_ok[1] = 1'b1;
      row_ok[2] = res_row + 1 < h;
      col_ok[0] = res_col > 0;
      col_ok[1] = 1'b1;
      col_ok[2] = res_col + 1 < w;
      for (ch = 0; ch < bbr_pkg::NCHAN; ch++) begin
         sum = 0;
         for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
               if (row_ok[r] && col_ok[c]) sum += win_px[r][c][ch];
         avg[ch] = 8'(sum / BOX_TAPS);
      end
      last = res_row + 1 >= h && res_col + 1 >= w;
      res.out_red = avg[0];
      res.out_green = avg[1];
      res.out_blue = avg[2];
      res.out_alpha = avg[3];
      res.frame_last = last;
      blurred_px.push_back(res);
      if (last) begin
         clear_frame();
      end else if (res_col + 1 >= w) begin
         res_col = 0;
         res_row = (res_row + 1) % (1 << bbr_pkg::ROW_W);
      end else begin
         res_col++;
      end
   endtask

   // feed side
   always @(posedge clock) begin
      bbr_pkg::req_type nxt;
      logic valid_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         valid_next = req_valid;
         nxt = req_data;
         if (req_valid && !req_stall) begin
            blur_step(req_data);
            items_taken++;
            valid_next = 1'b0;
         end
         if (!valid_next && pixel_feed.size() > 0 && $urandom_range(99) >= feed_gap_pct) begin
            nxt = pixel_feed.pop_front();
            valid_next = 1'b1;
         end
         req_valid <= valid_next;
         req_data <= nxt;
      end
   end

   // result side
   always @(posedge clock) begin
      bbr_pkg::rsp_type want;
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            if (blurred_px.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result beat %h", $realtime, rsp_data);
            end else begin
               want = blurred_px.pop_front();
               if (rsp_data.out_red !== want.out_red || rsp_data.out_green !== want.out_green
                   || rsp_data.out_blue !== want.out_blue
                   || rsp_data.out_alpha !== want.out_alpha
                   || rsp_data.frame_last !== want.frame_last) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: beat %0d exp %h/%h/%h/%h/%b got %h/%h/%h/%h/%b",
                              $realtime, rsp_beats, want.out_red, want.out_green,
                              want.out_blue, want.out_alpha, want.frame_last,
                              rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                              rsp_data.out_alpha, rsp_data.frame_last);
               end
            end
            // long back-pressure so the line pipeline fills and stalls the input
            if (rsp_beats == 300 || rsp_beats == 5000) hold_left = 400;
         end
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end else begin
            stall_next = $urandom_range(99) < sink_stall_pct;
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic csr_write(input bbr_pkg::csr_index_type idx,
                            input logic [bbr_pkg::CSR_DATA_W-1:0] val, input bit more);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == bbr_pkg::CSR_IMAGE_WIDTH) cfg_width = val[bbr_pkg::WIDTH_W-1:0];
      else if (idx == bbr_pkg::CSR_IMAGE_HEIGHT) cfg_height = val[bbr_pkg::ROW_W-1:0];
      if (!more) csr_valid <= 1'b0;
   endtask

   function automatic bbr_pkg::req_type pixel_item();
      bbr_pkg::req_type p;
      int pick;
      pick = $urandom_range(7);
      p = bbr_pkg::req_type'($urandom) << 1;
      if (pick == 0) p = '1;
      else if (pick == 1) p = '0;
      p.flush = 1'b0;
      return p;
   endfunction

   function automatic bbr_pkg::req_type flush_item();
      bbr_pkg::req_type p;
      p = bbr_pkg::req_type'($urandom) << 1;
      p.flush = 1'b1;
      return p;
   endfunction

   task automatic push_item(input bbr_pkg::req_type p);
      pixel_feed.push_back(p);
      items_pushed++;
   endtask

   task automatic wait_quiet();
      while (items_taken != items_pushed || blurred_px.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // a drain that wrapped the row counter needs more flush beats
   task automatic finish_frame();
      wait_quiet();
      while (drain_on) begin
         push_item(flush_item());
         wait_quiet();
      end
   endtask

   task automatic run_frame(input bit noisy);
      int w, h, i;
      w = eff_w();
      h = eff_h();
      for (i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(9) == 0) push_item(flush_item());
         push_item(pixel_item());
      end
      for (i = 0; i <= w; i++) begin
         if (noisy && $urandom_range(9) == 0) push_item(pixel_item());
         push_item(flush_item());
      end
      if (noisy && $urandom_range(3) == 0) push_item(flush_item());
      finish_frame();
   endtask

   initial begin
      int w_val, h_val, i;
      cfg_width = bbr_pkg::RESET_WIDTH;
      cfg_height = bbr_pkg::RESET_HEIGHT;
      for (i = 0; i < bbr_pkg::MAX_WIDTH; i++) begin
         line_upper[i] = '0;
         line_middle[i] = '0;
      end
      clear_frame();
      feed_gap_pct = 33;
      sink_stall_pct = 71;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // height left at its reset value, single column
      csr_write(bbr_pkg::CSR_IMAGE_WIDTH, 16'hF801, 1'b0);
      run_frame(1'b0);

      // 3x3 frame with full-scale pixels and ignored beats in both states
      csr_write(bbr_pkg::CSR_IMAGE_WIDTH, 16'd3, 1'b1);
      csr_write(bbr_pkg::CSR_IMAGE_HEIGHT, 16'd3, 1'b0);
      push_item('1 & ~bbr_pkg::req_type'(1));
      push_item('0);
      push_item(flush_item());
      for (i = 0; i < 7; i++) push_item(pixel_item());
      push_item(pixel_item());
      for (i = 0; i < 4; i++) push_item(flush_item());
      push_item(flush_item());
      finish_frame();

      // zero size acts as one, spare index has no effect
      csr_write(bbr_pkg::CSR_IMAGE_WIDTH, 16'hF800, 1'b1);
      csr_write(bbr_pkg::CSR_IMAGE_HEIGHT, 16'hE000, 1'b1);
      csr_write(CSR_SPARE, 16'hFFFF, 1'b0);
      push_item('1 & ~bbr_pkg::req_type'(1));
      push_item(flush_item());
      push_item(flush_item());
      finish_frame();

      while (items_pushed < 1050) begin
         if (items_pushed >= 700) begin
            feed_gap_pct = 0;
            sink_stall_pct = 0;
         end else if (items_pushed >= 350) begin
            feed_gap_pct = 71;
            sink_stall_pct = 33;
         end
         w_val = ($urandom_range(7) == 0) ? $urandom_range(40, 10) : $urandom_range(9);
         h_val = $urandom_range(6);
         csr_write(bbr_pkg::CSR_IMAGE_WIDTH,
                   (16'($urandom_range(31)) << bbr_pkg::WIDTH_W) | 16'(w_val), 1'b1);
         csr_write(bbr_pkg::CSR_IMAGE_HEIGHT,
                   (16'($urandom_range(7)) << bbr_pkg::ROW_W) | 16'(h_val), 1'b0);
         run_frame(1'b1);
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && blurred_px.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
